/* hw/rtl/i2da_pkg.sv */
// Shared types, constants and helper functions for the integer to decimal ASCII converter.
// Used by every module of the block; depends on nothing else.
package i2da_pkg;

  localparam int MAX_DIGITS  = 20;
  localparam int VALUE_W     = 64;
  localparam int NUM_BCD     = 20;
  localparam int BCD_W       = NUM_BCD * 4;
  localparam int BCD_IDX_W   = $clog2(BCD_W);
  localparam int CNT_W       = 5;
  localparam int CHAR_W      = 8;
  localparam int STEP_BITS   = 4;
  localparam int NUM_STEPS   = VALUE_W / STEP_BITS;
  localparam int STEP_CNT_W  = $clog2(NUM_STEPS);
  localparam int DEST_LEN_W  = 8;
  localparam int SRC_BITS_W  = 7;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic [DEST_LEN_W-1:0] DEST_LEN_RESET = 8'd21;
  localparam logic [SRC_BITS_W-1:0] SRC_BITS_RESET = 7'd64;
  localparam logic [CHAR_W-1:0]     ASCII_ZERO     = 8'h30;

  localparam logic [SRC_BITS_W-1:0] SRC_W8  = 7'd8;
  localparam logic [SRC_BITS_W-1:0] SRC_W10 = 7'd10;
  localparam logic [SRC_BITS_W-1:0] SRC_W13 = 7'd13;
  localparam logic [SRC_BITS_W-1:0] SRC_W16 = 7'd16;
  localparam logic [SRC_BITS_W-1:0] SRC_W32 = 7'd32;
  localparam logic [SRC_BITS_W-1:0] SRC_W64 = 7'd64;

  localparam logic REG_DEST_LEN = 1'b0;
  localparam logic REG_SRC_BITS = 1'b1;

  typedef enum logic [1:0] {
    WSEL_8,
    WSEL_16,
    WSEL_32,
    WSEL_64
  } wsel_t;

  typedef struct packed {
    logic             err;
    wsel_t            wsel;
    logic [CNT_W-1:0] limit;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_COUNT,
    S_EMIT,
    S_ERR
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic count;
    logic emit;
    logic err;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic last_digit;
  } stat_t;

  function automatic cfg_t cfg_decode(input logic [DEST_LEN_W-1:0] dest_len,
                                      input logic [SRC_BITS_W-1:0] src_bits);
    cfg_t                  c;
    logic [DEST_LEN_W-1:0] dm1;
    c.err  = 1'b0;
    c.wsel = WSEL_64;
    unique case (src_bits) inside
      SRC_W8:                    c.wsel = WSEL_8;
      SRC_W10, SRC_W13, SRC_W16: c.wsel = WSEL_16;
      SRC_W32:                   c.wsel = WSEL_32;
      SRC_W64:                   c.wsel = WSEL_64;
      default:                   c.err  = 1'b1;
    endcase
    if (dest_len < 8'd2) begin
      c.err = 1'b1;
    end
    dm1 = dest_len - 8'd1;
    if (dm1 > DEST_LEN_W'(MAX_DIGITS)) begin
      c.limit = CNT_W'(MAX_DIGITS);
    end else begin
      c.limit = dm1[CNT_W-1:0];
    end
    return c;
  endfunction

  function automatic logic [VALUE_W-1:0] mask_value(input logic [VALUE_W-1:0] v,
                                                    input wsel_t w);
    logic [VALUE_W-1:0] m;
    unique case (w)
      WSEL_8:  m = {{(VALUE_W-8){1'b0}}, v[7:0]};
      WSEL_16: m = {{(VALUE_W-16){1'b0}}, v[15:0]};
      WSEL_32: m = {{(VALUE_W-32){1'b0}}, v[31:0]};
      default: m = v;
    endcase
    return m;
  endfunction

endpackage

/* hw/rtl/i2da_regs.sv */
// Configuration registers with their APB-style access port and the decode of their settings.
// Depends on i2da_pkg.
module i2da_regs import i2da_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [APB_ADDR_W-1:0] cfg_paddr,
  input  logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic [APB_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output cfg_t                  cfg
);

  logic [DEST_LEN_W-1:0] dest_len_r, dest_len_nxt;
  logic [SRC_BITS_W-1:0] src_bits_r, src_bits_nxt;
  logic                  wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    dest_len_nxt = dest_len_r;
    src_bits_nxt = src_bits_r;
    if (wr_en) begin
      unique case (cfg_paddr[2])
        REG_DEST_LEN: dest_len_nxt = cfg_pwdata[DEST_LEN_W-1:0];
        REG_SRC_BITS: src_bits_nxt = cfg_pwdata[SRC_BITS_W-1:0];
        default:      dest_len_nxt = dest_len_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_len_r <= DEST_LEN_RESET;
      src_bits_r <= SRC_BITS_RESET;
    end else begin
      dest_len_r <= dest_len_nxt;
      src_bits_r <= src_bits_nxt;
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_SRC_BITS: cfg_prdata = {{(APB_DATA_W-SRC_BITS_W){1'b0}}, src_bits_r};
      default:      cfg_prdata = {{(APB_DATA_W-DEST_LEN_W){1'b0}}, dest_len_r};
    endcase
  end

  assign cfg = cfg_decode(dest_len_r, src_bits_r);

endmodule

/* hw/rtl/i2da_ctrl.sv */
// Controller FSM: sequences load, binary to BCD steps, digit count and digit or error output.
// Depends on i2da_pkg.
module i2da_ctrl import i2da_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  logic  cfg_err,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t                  state_r, state_nxt;
  logic [STEP_CNT_W-1:0]   step_cnt_r, step_cnt_nxt;
  logic                    last_step;

  assign last_step = (step_cnt_r == STEP_CNT_W'(NUM_STEPS - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = cfg_err ? S_ERR : S_CONV;
        end
      end
      S_CONV: begin
        if (last_step) begin
          state_nxt = S_COUNT;
        end
      end
      S_COUNT: state_nxt = S_EMIT;
      S_EMIT: begin
        if (stat.out_free && stat.last_digit) begin
          state_nxt = S_IDLE;
        end
      end
      S_ERR: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_tready    = 1'b0;
    step_cnt_nxt = step_cnt_r;
    unique case (state_r)
      S_IDLE: begin
        in_tready    = 1'b1;
        cmd.load     = in_tvalid & ~cfg_err;
        step_cnt_nxt = '0;
      end
      S_CONV: begin
        cmd.step     = 1'b1;
        step_cnt_nxt = step_cnt_r + 1'b1;
      end
      S_COUNT: cmd.count = 1'b1;
      S_EMIT:  cmd.emit  = stat.out_free;
      S_ERR:   cmd.err   = stat.out_free;
      default: cmd       = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      step_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      step_cnt_r <= step_cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_conv_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CONV |=> (state_r == S_CONV || state_r == S_COUNT))
    else $error("conversion left to an unexpected state");

  a_count_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_COUNT |=> state_r == S_EMIT)
    else $error("count state did not lead to digit output");
`endif

endmodule

/* hw/rtl/i2da_dp.sv */
// Datapath: masked value, shift-and-add-3 BCD converter, digit count and output register.
// Depends on i2da_pkg; driven by i2da_ctrl through command and status structs.
module i2da_dp import i2da_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  cfg_t               cfg,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [15:0]        out_tdata,
  output logic               out_tlast,
  output logic               out_tuser
);

  logic [VALUE_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [CNT_W-1:0]   ndig_r, idx_r;
  logic [CNT_W-1:0]   nz, total;
  logic               out_valid_r;
  logic [CHAR_W-1:0]  char_r;
  logic               last_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               status_r;
  logic [3:0]         cur_digit;

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    for (int s = 0; s < STEP_BITS; s++) begin
      for (int i = 0; i < NUM_BCD; i++) begin
        if (bcd_nxt[i*4 +: 4] >= 4'd5) begin
          bcd_nxt[i*4 +: 4] = bcd_nxt[i*4 +: 4] + 4'd3;
        end
      end
      bcd_nxt = {bcd_nxt[BCD_W-2:0], bin_nxt[VALUE_W-1]};
      bin_nxt = {bin_nxt[VALUE_W-2:0], 1'b0};
    end
  end

  always_comb begin
    nz = CNT_W'(1);
    for (int i = 1; i < NUM_BCD; i++) begin
      if (bcd_r[i*4 +: 4] != 4'd0) begin
        nz = CNT_W'(i + 1);
      end
    end
    total = (nz > cfg.limit) ? cfg.limit : nz;
  end

  assign cur_digit       = bcd_r[{idx_r, 2'b00} +: 4];
  assign stat.out_free   = ~out_valid_r | out_tready;
  assign stat.last_digit = (idx_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin_r <= mask_value(in_value, cfg.wsel);
      bcd_r <= '0;
    end else if (cmd.step) begin
      bin_r <= bin_nxt;
      bcd_r <= bcd_nxt;
    end
    if (cmd.count) begin
      ndig_r <= total;
      idx_r  <= total - 1'b1;
    end else if (cmd.emit && !stat.last_digit) begin
      idx_r <= idx_r - 1'b1;
    end
    if (cmd.emit) begin
      char_r   <= ASCII_ZERO + {4'd0, cur_digit};
      last_r   <= stat.last_digit;
      cnt_r    <= ndig_r;
      status_r <= 1'b0;
    end else if (cmd.err) begin
      char_r   <= '0;
      last_r   <= 1'b1;
      cnt_r    <= '0;
      status_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.err) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, cnt_r, char_r};
  assign out_tlast  = last_r;
  assign out_tuser  = status_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.count |=> (ndig_r >= CNT_W'(1) && ndig_r <= CNT_W'(MAX_DIGITS)))
    else $error("digit count out of range");

  a_emit_index: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> idx_r < ndig_r)
    else $error("digit index beyond digit count");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r |-> last_r && cnt_r == '0 && char_r == '0)
    else $error("error transaction carries digit data");
`endif

endmodule

/* hw/rtl/integer_to_decimal_ascii.sv */
// Unsigned integer to decimal ASCII converter, top level.
// A value accepted in idle is loaded, converted by 16 passes of a 4-bit shift-and-add-3 BCD
// converter, its digits counted in a count state, and then output one digit per cycle while
// the output is not stalled; a value gives N digits (at most 20). An error transaction is
// output once the output is free. The block takes no new value until the last one is out.
// Reset (synchronous, active low) restores dest_len 21, src_bits 64 and idles the block.
module integer_to_decimal_ascii import i2da_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [63:0]           in_tdata,     // [63:0] value
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,    // [7:0] char_out, [12:8] digit_count, [15:13] zero
  output logic                  out_tlast,
  output logic                  out_tuser,    // [0] status
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [APB_ADDR_W-1:0] cfg_paddr,
  input  logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic [APB_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  i2da_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  i2da_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cfg_err   (cfg.err),
    .stat      (stat),
    .cmd       (cmd)
  );

  i2da_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .cfg        (cfg),
    .in_value   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
